@@ src/mexp_pkg.sv @@
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared widths, reset values and datapath command codes for the modular
// exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam int DATA_W     = 31;              // modulus, base, exponent, residue
    localparam int MUL_STEPS  = DATA_W;          // one multiplier bit per step
    localparam int STEP_CNT_W = $clog2(MUL_STEPS + 1);
    localparam int IDX_W      = 1;               // two configuration registers

    localparam logic [DATA_W-1:0] MOD_RESET  = 31'd8191;
    localparam logic [DATA_W-1:0] BASE_RESET = 31'd3;

    typedef enum logic [IDX_W-1:0] {
        REG_MODULUS = 1'b0,
        REG_BASE    = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        OP_NOP      = 3'd0,
        OP_LOAD     = 3'd1,   // capture exponent, start base reduction
        OP_ZERO     = 3'd2,   // degenerate modulus, result is zero
        OP_STEP     = 3'd3,   // one shift-add-reduce step
        OP_RED_END  = 3'd4,   // keep reduced base, start first square
        OP_TO_MUL   = 3'd5,   // keep square, start multiply by base
        OP_SQR_NEXT = 3'd6,   // keep product, move to next bit, start square
        OP_FINISH   = 3'd7    // keep last product as the result
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic exp_msb;        // exponent bit under scan
        logic mod_small;      // modulus below two
    } t_dp_sts;

endpackage

@@ src/mexp_dp.sv @@
// ----------------------------------------------------------------------------
// mexp_dp
// Datapath: interleaved shift-add modular multiplier, one multiplier bit per
// cycle, with the exponent shifter and the result register.
// ----------------------------------------------------------------------------
module mexp_dp #(
    parameter int EXP_BITS = 31
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mexp_pkg::t_dp_cmd             i_cmd,
    input  logic [mexp_pkg::DATA_W-1:0]   i_modulus,
    input  logic [mexp_pkg::DATA_W-1:0]   i_base,
    input  logic [mexp_pkg::DATA_W-1:0]   i_exponent,
    output mexp_pkg::t_dp_sts             o_sts,
    output logic [mexp_pkg::DATA_W-1:0]   o_residue
);

    localparam int DW = mexp_pkg::DATA_W;

    logic [DW-1:0]       r_acc;    // partial product, kept below modulus
    logic [DW-1:0]       r_a;      // multiplier, scanned from the top bit
    logic [DW-1:0]       r_b;      // multiplicand, below modulus
    logic [DW-1:0]       r_bred;   // base mod modulus
    logic [DW-1:0]       r_res;
    logic [EXP_BITS-1:0] r_exp;

    logic [DW+1:0] sum;
    logic [DW+1:0] mod1;
    logic [DW+1:0] mod2;
    logic [DW+1:0] red;
    logic [DW-1:0] step_res;

    // 2*acc + bit*b stays below 3m, so one subtraction of 2m or of m reduces it
    always_comb begin
        mod1 = {2'b00, i_modulus};
        mod2 = {1'b0, i_modulus, 1'b0};
        sum  = {1'b0, r_acc, 1'b0} + (r_a[DW-1] ? {2'b00, r_b} : '0);
        if (sum >= mod2) begin
            red = sum - mod2;
        end else if (sum >= mod1) begin
            red = sum - mod1;
        end else begin
            red = sum;
        end
        step_res = red[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            mexp_pkg::OP_LOAD: begin
                r_exp <= EXP_BITS'(i_exponent);
                r_res <= DW'(1);
                r_acc <= '0;
                r_a   <= i_base;
                r_b   <= DW'(1);
            end
            mexp_pkg::OP_ZERO: begin
                r_res <= '0;
            end
            mexp_pkg::OP_STEP: begin
                r_acc <= step_res;
                r_a   <= {r_a[DW-2:0], 1'b0};
            end
            mexp_pkg::OP_RED_END: begin
                r_bred <= r_acc;
                r_a    <= r_res;
                r_b    <= r_res;
                r_acc  <= '0;
            end
            mexp_pkg::OP_TO_MUL: begin
                r_res <= r_acc;
                r_a   <= r_acc;
                r_b   <= r_bred;
                r_acc <= '0;
            end
            mexp_pkg::OP_SQR_NEXT: begin
                r_res <= r_acc;
                r_a   <= r_acc;
                r_b   <= r_acc;
                r_acc <= '0;
                r_exp <= r_exp << 1;
            end
            mexp_pkg::OP_FINISH: begin
                r_res <= r_acc;
            end
            default: begin
            end
        endcase
    end

    assign o_sts.exp_msb   = r_exp[EXP_BITS-1];
    assign o_sts.mod_small = (i_modulus < DW'(2));
    assign o_residue       = r_res;

    // partial product stays reduced through every step
    a_acc_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == mexp_pkg::OP_STEP) |=> (r_acc < i_modulus))
        else $error("partial product not reduced");

    // multiplicand below modulus whenever a step uses it
    a_b_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == mexp_pkg::OP_STEP) |-> (r_b < i_modulus))
        else $error("multiplicand not reduced");

endmodule

@@ src/mexp_ctrl.sv @@
// ----------------------------------------------------------------------------
// mexp_ctrl
// Controller: sequences base reduction, then a square and an optional multiply
// per exponent bit (or a zero result for a modulus below two), and flags the result word.
// ----------------------------------------------------------------------------
module mexp_ctrl #(
    parameter int EXP_BITS = 31
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    output logic              o_valid,
    input  mexp_pkg::t_dp_sts i_sts,
    output mexp_pkg::t_dp_cmd o_cmd
);

    localparam int BITS_W = $clog2(EXP_BITS + 1);
    localparam int CW     = mexp_pkg::STEP_CNT_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RED  = 5'b00010,
        S_SQR  = 5'b00100,
        S_MUL  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [BITS_W-1:0] r_bits, n_bits;   // exponent bits left, current included
    logic              steps_done;

    assign steps_done = (r_cnt == CW'(mexp_pkg::MUL_STEPS));

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_bits    = r_bits;
        o_cmd.op  = mexp_pkg::OP_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cnt  = '0;
                    n_bits = BITS_W'(EXP_BITS);
                    if (i_sts.mod_small) begin
                        o_cmd.op = mexp_pkg::OP_ZERO;
                        n_state  = S_DONE;
                    end else begin
                        o_cmd.op = mexp_pkg::OP_LOAD;
                        n_state  = S_RED;
                    end
                end
            end
            S_RED: begin
                if (!steps_done) begin
                    o_cmd.op = mexp_pkg::OP_STEP;
                    n_cnt    = r_cnt + CW'(1);
                end else begin
                    o_cmd.op = mexp_pkg::OP_RED_END;
                    n_cnt    = '0;
                    n_state  = S_SQR;
                end
            end
            S_SQR: begin
                if (!steps_done) begin
                    o_cmd.op = mexp_pkg::OP_STEP;
                    n_cnt    = r_cnt + CW'(1);
                end else if (i_sts.exp_msb) begin
                    o_cmd.op = mexp_pkg::OP_TO_MUL;
                    n_cnt    = '0;
                    n_state  = S_MUL;
                end else if (r_bits == BITS_W'(1)) begin
                    o_cmd.op = mexp_pkg::OP_FINISH;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = mexp_pkg::OP_SQR_NEXT;
                    n_cnt    = '0;
                    n_bits   = r_bits - BITS_W'(1);
                end
            end
            S_MUL: begin
                if (!steps_done) begin
                    o_cmd.op = mexp_pkg::OP_STEP;
                    n_cnt    = r_cnt + CW'(1);
                end else if (r_bits == BITS_W'(1)) begin
                    o_cmd.op = mexp_pkg::OP_FINISH;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = mexp_pkg::OP_SQR_NEXT;
                    n_cnt    = '0;
                    n_bits   = r_bits - BITS_W'(1);
                    n_state  = S_SQR;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_bits  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_bits  <= n_bits;
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_one_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(mexp_pkg::MUL_STEPS))
        else $error("step counter overran");

    a_bits_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SQR) || (r_state == S_MUL)) |-> (r_bits != '0))
        else $error("bit counter empty while scanning");

endmodule

@@ src/modular_exponentiation.sv @@
// ----------------------------------------------------------------------------
// modular_exponentiation
// residue = base ^ exponent mod modulus, left-to-right square and multiply
// on a bit-serial modular multiplier.
//
//   channel  | ports                               | handshake
//   ---------+-------------------------------------+-----------------------
//   config   | i_cfg_we, i_cfg_idx, i_cfg_data     | write when i_cfg_we
//   input    | i_exponent                          | start && !busy
//   result   | o_residue                           | o_valid, one cycle
//
// Each modular product is 31 shift-add-reduce steps and one hand-over. An
// item runs a base reduction, then a square per exponent bit and a multiply
// per set bit among the low EXP_BITS exponent bits, before the result
// strobe; a modulus below two gives a zero result without any products.
// busy stays high through the strobe cycle; the multiplier loop sets the rate.
// Reset is synchronous: modulus 8191, base 3, controller idle.
// Results cannot be held off; the strobe is one cycle wide.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
    parameter int EXP_BITS = 31
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mexp_pkg::IDX_W-1:0]          i_cfg_idx,
    input  logic [mexp_pkg::DATA_W-1:0]         i_cfg_data,
    input  logic                                start,
    output logic                                busy,
    input  logic [mexp_pkg::DATA_W-1:0]         i_exponent,
    output logic                                o_valid,
    output logic [mexp_pkg::DATA_W-1:0]         o_residue
);

    logic [mexp_pkg::DATA_W-1:0] r_modulus;
    logic [mexp_pkg::DATA_W-1:0] r_base;
    mexp_pkg::t_dp_cmd           cmd;
    mexp_pkg::t_dp_sts           sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= mexp_pkg::MOD_RESET;
            r_base    <= mexp_pkg::BASE_RESET;
        end else if (i_cfg_we) begin
            unique case (mexp_pkg::t_reg_idx'(i_cfg_idx))
                mexp_pkg::REG_MODULUS: r_modulus <= i_cfg_data;
                mexp_pkg::REG_BASE:    r_base    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    mexp_ctrl #(
        .EXP_BITS (EXP_BITS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_valid (o_valid),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    mexp_dp #(
        .EXP_BITS (EXP_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_modulus  (r_modulus),
        .i_base     (r_base),
        .i_exponent (i_exponent),
        .o_sts      (sts),
        .o_residue  (o_residue)
    );

endmodule
